// File: design/vdp_pkg.sv
// shared types and constants for the palette port block
`timescale 1ns / 1ps

package vdp_pkg;

   localparam int PALETTE_ENTRIES_DEF = 256;

   localparam logic [7:0] BYTE_MASK = 8'hff;
   localparam logic [5:0] COMP_MASK = 6'h3f;
   localparam logic [7:0] MASK_RESET = BYTE_MASK;

   // component step codes
   localparam logic [1:0] STEP_RED = 2'd0;
   localparam logic [1:0] STEP_GREEN = 2'd1;
   localparam logic [1:0] STEP_BLUE = 2'd2;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_LOOKUP = 2'd2,
      OP_IDLE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      SEL_MASK   = 2'd0,
      SEL_RINDEX = 2'd1,
      SEL_WINDEX = 2'd2,
      SEL_DATA   = 2'd3
   } sel_type;

   typedef enum logic [1:0] {
      RES_ZERO  = 2'd0,
      RES_BYTE  = 2'd1,
      RES_COMP  = 2'd2,
      RES_PIXEL = 2'd3
   } res_type;

   typedef struct packed {
      logic       rd_en;
      logic [7:0] rd_addr;
      logic       wr_en;
      logic [7:0] wr_addr;
      logic [1:0] wr_step;
      logic [5:0] wr_data;
   } mem_req_type;

   typedef struct packed {
      res_type    kind;
      logic [1:0] step;
      logic [7:0] value;
   } stage_type;

   typedef struct packed {
      logic [5:0] red;
      logic [5:0] green;
      logic [5:0] blue;
   } pal_data_type;

endpackage

// File: design/vdp_ctrl.sv
// port registers, component step and transaction decode
`timescale 1ns / 1ps

module vdp_ctrl
   import vdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  op_type      op,
   input  sel_type     sel,
   input  logic [7:0]  write_data,
   input  logic [7:0]  pixel_value,
   output mem_req_type mem_req,
   output stage_type   stage_info
);

   logic [7:0] mask_ff, mask_in;
   logic [7:0] rptr_ff, rptr_in;
   logic [7:0] wptr_ff, wptr_in;
   logic [1:0] step_ff, step_in;
   logic       last_step;
   logic [1:0] step_next;

   assign last_step = (step_ff == STEP_BLUE);
   assign step_next = last_step ? STEP_RED : 2'(step_ff + 2'd1);

   always_comb begin
      mask_in = mask_ff;
      rptr_in = rptr_ff;
      wptr_in = wptr_ff;
      step_in = step_ff;
      if (accept) begin
         case (op)
            OP_WRITE: begin
               case (sel)
                  SEL_MASK: mask_in = write_data;
                  SEL_RINDEX: begin
                     rptr_in = write_data;
                     step_in = STEP_RED;
                  end
                  SEL_WINDEX: begin
                     wptr_in = write_data;
                     step_in = STEP_RED;
                  end
                  default: begin
                     step_in = step_next;
                     if (last_step) begin
                        wptr_in = 8'(wptr_ff + 8'd1);
                     end
                  end
               endcase
            end
            OP_READ: begin
               if (sel == SEL_DATA) begin
                  step_in = step_next;
                  if (last_step) begin
                     rptr_in = 8'(rptr_ff + 8'd1);
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      mem_req.rd_en = accept;
      mem_req.rd_addr = (op == OP_LOOKUP) ? (pixel_value & mask_ff) : rptr_ff;
      mem_req.wr_en = accept && (op == OP_WRITE) && (sel == SEL_DATA);
      mem_req.wr_addr = wptr_ff;
      mem_req.wr_step = step_ff;
      mem_req.wr_data = write_data[5:0] & COMP_MASK;

      stage_info.kind = RES_ZERO;
      stage_info.step = step_ff;
      stage_info.value = '0;
      case (op)
         OP_READ: begin
            case (sel)
               SEL_MASK: begin
                  stage_info.kind = RES_BYTE;
                  stage_info.value = mask_ff;
               end
               SEL_RINDEX: begin
                  stage_info.kind = RES_BYTE;
                  stage_info.value = rptr_ff;
               end
               SEL_WINDEX: begin
                  stage_info.kind = RES_BYTE;
                  stage_info.value = wptr_ff;
               end
               default: stage_info.kind = RES_COMP;
            endcase
         end
         OP_LOOKUP: stage_info.kind = RES_PIXEL;
         default: stage_info.kind = RES_ZERO;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
         rptr_ff <= '0;
         wptr_ff <= '0;
         step_ff <= STEP_RED;
      end else begin
         mask_ff <= mask_in;
         rptr_ff <= rptr_in;
         wptr_ff <= wptr_in;
         step_ff <= step_in;
      end
   end

`ifndef ASSERT_OFF
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff != 2'd3)
      else $error("component step out of range");

   a_index_clears_step: assert property (@(posedge clock) disable iff (reset)
      accept && (op == OP_WRITE) && (sel == SEL_RINDEX || sel == SEL_WINDEX)
      |=> step_ff == STEP_RED)
      else $error("index write did not clear component step");

   a_wptr_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && (op == OP_WRITE) && (sel == SEL_DATA) && (step_ff == STEP_BLUE)
      |=> wptr_ff == 8'($past(wptr_ff) + 8'd1))
      else $error("write index did not advance after blue");
`endif

endmodule

// File: design/vdp_ram.sv
// palette memory with per-component lanes and per-entry valid bits
`timescale 1ns / 1ps

module vdp_ram
   import vdp_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   input  mem_req_type  mem_req,
   output pal_data_type rd_data
);

   localparam int AddrW = $clog2(PALETTE_ENTRIES);

   logic [5:0] red_mem [PALETTE_ENTRIES];
   logic [5:0] green_mem [PALETTE_ENTRIES];
   logic [5:0] blue_mem [PALETTE_ENTRIES];

   logic [PALETTE_ENTRIES-1:0] valid_ff;
   logic [AddrW-1:0]           waddr;
   logic [AddrW-1:0]           raddr;
   logic                       wr_valid;
   logic [2:0]                 lane_we;
   logic [5:0]                 lane_data [3];
   pal_data_type               rd_data_ff;
   logic                       rd_valid_ff;

   assign waddr = mem_req.wr_addr[AddrW-1:0];
   assign raddr = mem_req.rd_addr[AddrW-1:0];
   assign wr_valid = valid_ff[waddr];

   // first write to an entry zeroes the other lanes
   always_comb begin
      lane_we[0] = mem_req.wr_en && (!wr_valid || mem_req.wr_step == STEP_RED);
      lane_we[1] = mem_req.wr_en && (!wr_valid || mem_req.wr_step == STEP_GREEN);
      lane_we[2] = mem_req.wr_en && (!wr_valid || mem_req.wr_step == STEP_BLUE);
      lane_data[0] = (mem_req.wr_step == STEP_RED) ? mem_req.wr_data : '0;
      lane_data[1] = (mem_req.wr_step == STEP_GREEN) ? mem_req.wr_data : '0;
      lane_data[2] = (mem_req.wr_step == STEP_BLUE) ? mem_req.wr_data : '0;
   end

   always_ff @(posedge clock) begin
      if (lane_we[0]) begin
         red_mem[waddr] <= lane_data[0];
      end
      if (lane_we[1]) begin
         green_mem[waddr] <= lane_data[1];
      end
      if (lane_we[2]) begin
         blue_mem[waddr] <= lane_data[2];
      end
      if (mem_req.rd_en) begin
         rd_data_ff.red <= red_mem[raddr];
         rd_data_ff.green <= green_mem[raddr];
         rd_data_ff.blue <= blue_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            valid_ff[waddr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_valid_ff <= valid_ff[raddr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// File: design/vdp_resp.sv
// pipeline stage, result formatting and output register
`timescale 1ns / 1ps

module vdp_resp
   import vdp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  stage_type    stage_info,
   input  pal_data_type rd_data,
   output logic         req_ready,
   input  logic         rsp_tready,
   output logic         rsp_tvalid,
   output logic [31:0]  rsp_tdata
);

   logic        stage_valid_ff, stage_valid_in;
   stage_type   stage_ff;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_data_ff;
   logic        stage_move;
   logic [7:0]  rdata;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [5:0]  comp;

   assign stage_move = stage_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_ready = !stage_valid_ff || stage_move;

   always_comb begin
      case (stage_ff.step)
         STEP_RED: comp = rd_data.red;
         STEP_GREEN: comp = rd_data.green;
         STEP_BLUE: comp = rd_data.blue;
         default: comp = '0;
      endcase
      rdata = '0;
      red = '0;
      green = '0;
      blue = '0;
      case (stage_ff.kind)
         RES_BYTE: rdata = stage_ff.value;
         RES_COMP: rdata = {2'b00, comp};
         RES_PIXEL: begin
            red = {rd_data.red, 2'b00};
            green = {rd_data.green, 2'b00};
            blue = {rd_data.blue, 2'b00};
         end
         default: ;
      endcase
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (stage_move) begin
         stage_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (stage_move) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_info;
      end
      if (stage_move) begin
         out_data_ff <= {blue, green, red, rdata};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;

`ifndef ASSERT_OFF
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      stage_move && (stage_ff.kind == RES_ZERO) |=> out_data_ff == '0)
      else $error("write or idle transaction gave nonzero result");

   a_pixel_widen: assert property (@(posedge clock) disable iff (reset)
      stage_move |=> (out_data_ff[9:8] == 2'b00) && (out_data_ff[17:16] == 2'b00)
      && (out_data_ff[25:24] == 2'b00))
      else $error("color component not widened by two");
`endif

endmodule

// File: design/vga_dac_palette_port_top.sv
// top level of the palette port block
//
//   channel   dir   tdata                                   tuser
//   req       in    write_data, pixel_value                 operation, reg_select
//   rsp       out   read_data, red, green, blue             -
//
// one transaction per cycle is taken while rsp_tready stays high
// a result passes through the registered palette read port and stage register,
// followed by the output register
// reset clears all palette valid bits at once, so no sweep follows reset
// rsp_tready low holds the output register; req_tready drops once the
// stage behind it is also full
`timescale 1ns / 1ps

module vga_dac_palette_port_top
   import vdp_pkg::*;
#(
   parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // write_data, pixel_value
   input  logic [3:0]  req_tuser,  // operation, reg_select
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // read_data, red, green, blue
);

   logic         accept;
   mem_req_type  mem_req;
   stage_type    stage_info;
   pal_data_type rd_data;

   assign accept = req_tvalid && req_tready;

   vdp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .op          (op_type'(req_tuser[1:0])),
      .sel         (sel_type'(req_tuser[3:2])),
      .write_data  (req_tdata[7:0]),
      .pixel_value (req_tdata[15:8]),
      .mem_req     (mem_req),
      .stage_info  (stage_info)
   );

   vdp_ram #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   vdp_resp u_resp (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .stage_info (stage_info),
      .rd_data    (rd_data),
      .req_ready  (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
